[hdl/acw_pkg.sv]
package acw_pkg;

    // Default field widths
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    // Register port geometry: one 64-bit register every 8 bytes
    localparam int PDATA_W  = 64;
    localparam int PADDR_W  = 6;
    localparam int ADDR_LSB = 3;
    localparam int IDX_W    = PADDR_W - ADDR_LSB;

    // Register field widths
    localparam int THR_SQ_W = 36;
    localparam int AXIS_W   = 15;
    localparam int MS_W     = 32;
    localparam int ROT_W    = 2;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_MOTION_THR_SQ = 3'd0,
        REG_AXIS_THR      = 3'd1,
        REG_DOM_MARGIN    = 3'd2,
        REG_DWELL_MS      = 3'd3,
        REG_TIMEOUT_MS    = 3'd4,
        REG_ROT_PRESET    = 3'd5
    } t_reg_idx;

    // Register reset values
    localparam logic [THR_SQ_W-1:0] RST_MOTION_THR_SQ = 36'd242064;
    localparam logic [AXIS_W-1:0]   RST_AXIS_THR      = 15'd2867;
    localparam logic [AXIS_W-1:0]   RST_DOM_MARGIN    = 15'd737;
    localparam logic [MS_W-1:0]     RST_DWELL_MS      = 32'd500;
    localparam logic [MS_W-1:0]     RST_TIMEOUT_MS    = 32'd1000;
    localparam logic [ROT_W-1:0]    RST_ROT_PRESET    = 2'd0;

    // Display rotation codes
    localparam logic [ROT_W-1:0] ROT_Y_POS = 2'd0;
    localparam logic [ROT_W-1:0] ROT_X_NEG = 2'd1;
    localparam logic [ROT_W-1:0] ROT_Y_NEG = 2'd2;
    localparam logic [ROT_W-1:0] ROT_X_POS = 2'd3;

    // Static settings seen by the datapath
    typedef struct packed {
        logic [THR_SQ_W-1:0] motion_thr_sq;
        logic [AXIS_W-1:0]   axis_thr;
        logic [AXIS_W-1:0]   dom_margin;
        logic [MS_W-1:0]     dwell_ms;
        logic [MS_W-1:0]     timeout_ms;
    } t_cfg;

    // Rotation preset write event
    typedef struct packed {
        logic             wr;
        logic [ROT_W-1:0] rot;
    } t_preset;

endpackage

[hdl/acw_sample_if.sv]
interface acw_sample_if #(
    parameter int SAMPLE_BITS = acw_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = acw_pkg::TIME_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic [TIME_BITS-1:0]          time_ms;

    modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

[hdl/acw_result_if.sv]
interface acw_result_if;
    logic       valid;
    logic       ready;
    logic       wake;
    logic [1:0] rotation;
    logic       rot_adopted;

    modport source (output valid, wake, rotation, rot_adopted, input ready);
    modport sink   (input valid, wake, rotation, rot_adopted, output ready);
endinterface

[hdl/accel_wake_and_orientation.sv]
// The sample passes the input register, then the result register, before its
// result can transfer. Throughput: one sample per cycle while the result side
// does not stall; the detector state loop (reference, pending flag, candidate)
// closes combinationally from the input register into the state registers.
// Reset: synchronous, active low; state clears to zero and the registers load
// their defaults, no clearing pass.
module accel_wake_and_orientation #(
    parameter int SAMPLE_BITS = acw_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = acw_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    acw_sample_if.sink                   i_sample,
    acw_result_if.source                 o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acw_pkg::PADDR_W-1:0]  paddr,
    input  logic [acw_pkg::PDATA_W-1:0]  pwdata,
    output logic [acw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import acw_pkg::*;

    t_cfg    cfg;
    t_preset preset;

    // Register file
    acw_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_preset (preset)
    );

    // Detector datapath
    acw_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_preset (preset),
        .i_sample (i_sample),
        .o_result (o_result)
    );

endmodule

[hdl/acw_cfg.sv]
module acw_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acw_pkg::PADDR_W-1:0]  paddr,
    input  logic [acw_pkg::PDATA_W-1:0]  pwdata,
    output logic [acw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output acw_pkg::t_cfg                o_cfg,
    output acw_pkg::t_preset             o_preset
);
    import acw_pkg::*;

    logic [THR_SQ_W-1:0] r_motion_thr_sq;
    logic [AXIS_W-1:0]   r_axis_thr;
    logic [AXIS_W-1:0]   r_dom_margin;
    logic [MS_W-1:0]     r_dwell_ms;
    logic [MS_W-1:0]     r_timeout_ms;
    logic [ROT_W-1:0]    r_rot_preset;

    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:ADDR_LSB]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_thr_sq <= RST_MOTION_THR_SQ;
            r_axis_thr      <= RST_AXIS_THR;
            r_dom_margin    <= RST_DOM_MARGIN;
            r_dwell_ms      <= RST_DWELL_MS;
            r_timeout_ms    <= RST_TIMEOUT_MS;
            r_rot_preset    <= RST_ROT_PRESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_MOTION_THR_SQ: r_motion_thr_sq <= pwdata[THR_SQ_W-1:0];
                REG_AXIS_THR:      r_axis_thr      <= pwdata[AXIS_W-1:0];
                REG_DOM_MARGIN:    r_dom_margin    <= pwdata[AXIS_W-1:0];
                REG_DWELL_MS:      r_dwell_ms      <= pwdata[MS_W-1:0];
                REG_TIMEOUT_MS:    r_timeout_ms    <= pwdata[MS_W-1:0];
                REG_ROT_PRESET:    r_rot_preset    <= pwdata[ROT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (idx)
            REG_MOTION_THR_SQ: prdata = PDATA_W'(r_motion_thr_sq);
            REG_AXIS_THR:      prdata = PDATA_W'(r_axis_thr);
            REG_DOM_MARGIN:    prdata = PDATA_W'(r_dom_margin);
            REG_DWELL_MS:      prdata = PDATA_W'(r_dwell_ms);
            REG_TIMEOUT_MS:    prdata = PDATA_W'(r_timeout_ms);
            REG_ROT_PRESET:    prdata = PDATA_W'(r_rot_preset);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.motion_thr_sq = r_motion_thr_sq;
    assign o_cfg.axis_thr      = r_axis_thr;
    assign o_cfg.dom_margin    = r_dom_margin;
    assign o_cfg.dwell_ms      = r_dwell_ms;
    assign o_cfg.timeout_ms    = r_timeout_ms;

    // Preset acts on the datapath in the cycle of the write transfer
    assign o_preset.wr  = wr_en && (idx == REG_ROT_PRESET);
    assign o_preset.rot = pwdata[ROT_W-1:0];

endmodule

[hdl/acw_core.sv]
module acw_core #(
    parameter int SAMPLE_BITS = acw_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = acw_pkg::TIME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  acw_pkg::t_cfg    i_cfg,
    input  acw_pkg::t_preset i_preset,
    acw_sample_if.sink       i_sample,
    acw_result_if.source     o_result
);
    import acw_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int TB = TIME_BITS;
    localparam int SQ_W = 2 * SB + 2;
    localparam int D_W  = SQ_W + 2;
    localparam int C_W  = (D_W > THR_SQ_W) ? D_W : THR_SQ_W;
    localparam int M_W  = ((SB > AXIS_W) ? SB : AXIS_W) + 1;

    // Input register
    logic                 r_in_vld;
    logic signed [SB-1:0] r_x, r_y, r_z;
    logic [TB-1:0]        r_t;

    // Result register
    logic             r_out_vld;
    logic             r_wake;
    logic [ROT_W-1:0] r_rot_out;
    logic             r_chg;

    // Detector state
    logic [TB-1:0]        r_last_time, n_last_time;
    logic                 r_have_last, n_have_last;
    logic signed [SB-1:0] r_ref_x, r_ref_y, r_ref_z;
    logic signed [SB-1:0] n_ref_x, n_ref_y, n_ref_z;
    logic                 r_have_ref, n_have_ref;
    logic                 r_pend, n_pend;
    logic [ROT_W-1:0]     r_cur_rot, n_cur_rot;
    logic                 r_cand_vld, n_cand_vld;
    logic [ROT_W-1:0]     r_cand_rot, n_cand_rot;
    logic [TB-1:0]        r_cand_since, n_cand_since;

    logic advance, in_ready;
    logic wake, chg;

    // Step intermediates
    logic [TB-1:0]        dt_last, dt_cand;
    logic                 timeout, pend_eff, cand_eff, have_ref_eff;
    logic signed [SB-1:0] ref_x_eff, ref_y_eff, ref_z_eff;
    logic signed [SB:0]   dx, dy, dz;
    logic [SB:0]          adx, ady, adz;
    logic [SQ_W-1:0]      sqx, sqy, sqz;
    logic [D_W-1:0]       dist_sq;
    logic                 moved;
    logic [SB-1:0]        ax, ay, az;
    logic                 x_dom, y_dom, prop_vld;
    logic [ROT_W-1:0]     prop_rot;

    // Handshake: the input stage moves on whenever the result register is empty or being taken
    assign advance        = r_in_vld && (!r_out_vld || o_result.ready);
    assign in_ready       = !r_in_vld || advance;
    assign i_sample.ready = in_ready;

    assign o_result.valid       = r_out_vld;
    assign o_result.wake        = r_wake;
    assign o_result.rotation    = r_rot_out;
    assign o_result.rot_adopted = r_chg;

    // Continuity check against the previous sample
    assign dt_last      = r_t - r_last_time;
    assign timeout      = r_have_last && (MS_W'(dt_last) >= i_cfg.timeout_ms);
    assign have_ref_eff = r_have_ref || timeout;
    assign pend_eff     = r_pend && !timeout;
    assign cand_eff     = r_cand_vld && !timeout;
    assign ref_x_eff    = timeout ? r_x : r_ref_x;
    assign ref_y_eff    = timeout ? r_y : r_ref_y;
    assign ref_z_eff    = timeout ? r_z : r_ref_z;

    // Squared distance from the reference
    assign dx   = $signed({r_x[SB-1], r_x}) - $signed({ref_x_eff[SB-1], ref_x_eff});
    assign dy   = $signed({r_y[SB-1], r_y}) - $signed({ref_y_eff[SB-1], ref_y_eff});
    assign dz   = $signed({r_z[SB-1], r_z}) - $signed({ref_z_eff[SB-1], ref_z_eff});
    assign adx  = dx[SB] ? (~dx + 1'b1) : dx;
    assign ady  = dy[SB] ? (~dy + 1'b1) : dy;
    assign adz  = dz[SB] ? (~dz + 1'b1) : dz;
    assign sqx  = adx * adx;
    assign sqy  = ady * ady;
    assign sqz  = adz * adz;
    assign dist_sq = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
    assign moved = C_W'(dist_sq) >= C_W'(i_cfg.motion_thr_sq);

    // Axis dominance
    assign ax = r_x[SB-1] ? (~r_x + 1'b1) : r_x;
    assign ay = r_y[SB-1] ? (~r_y + 1'b1) : r_y;
    assign az = r_z[SB-1] ? (~r_z + 1'b1) : r_z;

    assign x_dom = (M_W'(ax) >= M_W'(i_cfg.axis_thr))
                && (M_W'(ax) >= M_W'(ay) + M_W'(i_cfg.dom_margin))
                && (M_W'(ax) >= M_W'(az) + M_W'(i_cfg.dom_margin));
    assign y_dom = (M_W'(ay) >= M_W'(i_cfg.axis_thr))
                && (M_W'(ay) >= M_W'(ax) + M_W'(i_cfg.dom_margin))
                && (M_W'(ay) >= M_W'(az) + M_W'(i_cfg.dom_margin));

    always_comb begin
        prop_vld = 1'b1;
        if (x_dom) begin
            prop_rot = (!r_x[SB-1] && (r_x != '0)) ? ROT_X_POS : ROT_X_NEG;
        end else if (y_dom) begin
            prop_rot = (!r_y[SB-1] && (r_y != '0)) ? ROT_Y_POS : ROT_Y_NEG;
        end else begin
            prop_vld = 1'b0;
            prop_rot = r_cur_rot;
        end
    end

    assign dt_cand = r_t - r_cand_since;

    // Next state for the sample in the input register
    always_comb begin
        n_last_time  = r_t;
        n_have_last  = 1'b1;
        n_ref_x      = ref_x_eff;
        n_ref_y      = ref_y_eff;
        n_ref_z      = ref_z_eff;
        n_have_ref   = have_ref_eff;
        n_pend       = pend_eff;
        n_cur_rot    = r_cur_rot;
        n_cand_vld   = cand_eff;
        n_cand_rot   = r_cand_rot;
        n_cand_since = r_cand_since;
        wake         = 1'b0;
        chg          = 1'b0;

        // Motion: first sample seeds the reference, two hits in a row wake
        if (!have_ref_eff) begin
            n_ref_x    = r_x;
            n_ref_y    = r_y;
            n_ref_z    = r_z;
            n_have_ref = 1'b1;
        end else if (!moved) begin
            n_pend = 1'b0;
        end else if (!pend_eff) begin
            n_pend = 1'b1;
        end else begin
            n_pend  = 1'b0;
            n_ref_x = r_x;
            n_ref_y = r_y;
            n_ref_z = r_z;
            wake    = 1'b1;
        end

        // Orientation: start a candidate, adopt it once the dwell has passed
        if (!prop_vld || (prop_rot == r_cur_rot)) begin
            n_cand_vld = 1'b0;
        end else if (!cand_eff || (prop_rot != r_cand_rot)) begin
            n_cand_vld   = 1'b1;
            n_cand_rot   = prop_rot;
            n_cand_since = r_t;
        end else if (MS_W'(dt_cand) >= i_cfg.dwell_ms) begin
            n_cur_rot  = prop_rot;
            n_cand_vld = 1'b0;
            chg        = 1'b1;
        end
    end

    // Control and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_last_time  <= '0;
            r_have_last  <= 1'b0;
            r_ref_x      <= '0;
            r_ref_y      <= '0;
            r_ref_z      <= '0;
            r_have_ref   <= 1'b0;
            r_pend       <= 1'b0;
            r_cur_rot    <= '0;
            r_cand_vld   <= 1'b0;
            r_cand_rot   <= '0;
            r_cand_since <= '0;
        end else begin
            if (in_ready) begin
                r_in_vld <= i_sample.valid;
            end
            if (advance) begin
                r_out_vld    <= 1'b1;
                r_last_time  <= n_last_time;
                r_have_last  <= n_have_last;
                r_ref_x      <= n_ref_x;
                r_ref_y      <= n_ref_y;
                r_ref_z      <= n_ref_z;
                r_have_ref   <= n_have_ref;
                r_pend       <= n_pend;
                r_cur_rot    <= n_cur_rot;
                r_cand_vld   <= n_cand_vld;
                r_cand_rot   <= n_cand_rot;
                r_cand_since <= n_cand_since;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            // Preset: force the rotation, drop the candidate and the continuity
            if (i_preset.wr) begin
                r_cur_rot   <= i_preset.rot;
                r_cand_vld  <= 1'b0;
                r_have_last <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_sample.valid) begin
            r_x <= i_sample.accel_x;
            r_y <= i_sample.accel_y;
            r_z <= i_sample.accel_z;
            r_t <= i_sample.time_ms;
        end
        if (advance) begin
            r_wake    <= wake;
            r_rot_out <= n_cur_rot;
            r_chg     <= chg;
        end
    end

endmodule

[tb/tb_accel_wake_and_orientation.sv]
module tb_accel_wake_and_orientation;
    timeunit 1ns;
    timeprecision 1ps;

    import acw_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int TB = TIME_BITS_DEF;
    localparam int S_MAX = 2 ** (SB - 1) - 1;
    localparam int S_MIN = -(2 ** (SB - 1));

    localparam int RESET_CYCLES  = 7;
    localparam int DRAIN_SETTLE  = 4;
    localparam int END_SETTLE    = 10;
    localparam int WATCHDOG_QUIET = 3000;
    localparam int RX_HOLD_LEN   = 300;
    localparam int PHASE_ITEMS   = 76;
    localparam int N_IDLE        = 4;
    localparam int N_SETTINGS    = 5;

    // Index with no register behind it
    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(6);

    typedef struct {
        logic signed [SB-1:0] x;
        logic signed [SB-1:0] y;
        logic signed [SB-1:0] z;
        logic [TB-1:0]        t;
    } t_sample;

    typedef struct {
        logic             wake;
        logic [ROT_W-1:0] rotation;
        logic             changed;
    } t_result;

    typedef enum int {SET_DEFAULT, SET_ZERO, SET_MAX, SET_RANDOM} t_setting;
    typedef enum int {POSE_X_POS, POSE_X_NEG, POSE_Y_POS, POSE_Y_NEG, POSE_FLAT, POSE_WILD} t_pose;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    acw_sample_if smp_if ();
    acw_result_if res_if ();

    accel_wake_and_orientation u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor copy of the settings
    logic [THR_SQ_W-1:0] m_thr_sq;
    logic [AXIS_W-1:0]   m_axis_thr;
    logic [AXIS_W-1:0]   m_margin;
    logic [MS_W-1:0]     m_dwell;
    logic [MS_W-1:0]     m_timeout;

    // Predictor copy of the detector state
    logic [TB-1:0]        m_last_time;
    logic                 m_have_last;
    logic signed [SB-1:0] m_ref_x, m_ref_y, m_ref_z;
    logic                 m_have_ref;
    logic                 m_pending;
    logic [ROT_W-1:0]     m_cur_rot;
    logic                 m_cand_valid;
    logic [ROT_W-1:0]     m_cand_rot;
    logic [TB-1:0]        m_cand_since;

    t_result expected_q[$];
    int n_errors = 0;

    // Traffic shaping
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_cycles = 0;
    int idle_tx[N_IDLE] = '{0, 70, 0, 32};
    int idle_rx[N_IDLE] = '{0, 0, 70, 32};

    // Random sample generator state
    logic [TB-1:0] clock_ms = '0;
    int pose_left = 0;
    int pose_x, pose_y, pose_z;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_model();
        m_thr_sq     = RST_MOTION_THR_SQ;
        m_axis_thr   = RST_AXIS_THR;
        m_margin     = RST_DOM_MARGIN;
        m_dwell      = RST_DWELL_MS;
        m_timeout    = RST_TIMEOUT_MS;
        m_last_time  = '0;
        m_have_last  = 1'b0;
        m_ref_x      = '0;
        m_ref_y      = '0;
        m_ref_z      = '0;
        m_have_ref   = 1'b0;
        m_pending    = 1'b0;
        m_cur_rot    = RST_ROT_PRESET;
        m_cand_valid = 1'b0;
        m_cand_rot   = '0;
        m_cand_since = '0;
    endfunction

    function automatic void apply_config(logic [IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
        case (idx)
            REG_MOTION_THR_SQ: m_thr_sq = value[THR_SQ_W-1:0];
            REG_AXIS_THR:      m_axis_thr = value[AXIS_W-1:0];
            REG_DOM_MARGIN:    m_margin = value[AXIS_W-1:0];
            REG_DWELL_MS:      m_dwell = value[MS_W-1:0];
            REG_TIMEOUT_MS:    m_timeout = value[MS_W-1:0];
            REG_ROT_PRESET: begin
                m_cur_rot    = value[ROT_W-1:0];
                m_cand_valid = 1'b0;
                m_have_last  = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Advance the detector by one sample and return what it should report
    function automatic t_result predict_orientation(t_sample s);
        t_result r;
        logic [TB-1:0] gap;
        logic [TB-1:0] held;
        longint dx, dy, dz, dist_sq;
        int ax, ay, az, axis, mg;
        logic [ROT_W-1:0] prop;
        logic prop_ok;

        r.wake = 1'b0;
        r.changed = 1'b0;

        // Long silence: restart the motion measurement from this sample
        gap = s.t - m_last_time;
        if (m_have_last && gap >= m_timeout) begin
            m_ref_x = s.x;
            m_ref_y = s.y;
            m_ref_z = s.z;
            m_have_ref = 1'b1;
            m_pending = 1'b0;
            m_cand_valid = 1'b0;
        end
        m_last_time = s.t;
        m_have_last = 1'b1;

        // Motion needs two distant samples in a row
        if (!m_have_ref) begin
            m_ref_x = s.x;
            m_ref_y = s.y;
            m_ref_z = s.z;
            m_have_ref = 1'b1;
        end else begin
            dx = longint'(s.x) - longint'(m_ref_x);
            dy = longint'(s.y) - longint'(m_ref_y);
            dz = longint'(s.z) - longint'(m_ref_z);
            dist_sq = dx * dx + dy * dy + dz * dz;
            if (dist_sq < longint'(m_thr_sq)) begin
                m_pending = 1'b0;
            end else if (!m_pending) begin
                m_pending = 1'b1;
            end else begin
                m_pending = 1'b0;
                m_ref_x = s.x;
                m_ref_y = s.y;
                m_ref_z = s.z;
                r.wake = 1'b1;
            end
        end

        // Dominant axis gives the proposed rotation, x first
        ax = (s.x < 0) ? -int'(s.x) : int'(s.x);
        ay = (s.y < 0) ? -int'(s.y) : int'(s.y);
        az = (s.z < 0) ? -int'(s.z) : int'(s.z);
        axis = int'(m_axis_thr);
        mg = int'(m_margin);
        prop = ROT_Y_POS;
        prop_ok = 1'b1;
        if (ax >= axis && ax >= ay + mg && ax >= az + mg)
            prop = (s.x > 0) ? ROT_X_POS : ROT_X_NEG;
        else if (ay >= axis && ay >= ax + mg && ay >= az + mg)
            prop = (s.y > 0) ? ROT_Y_POS : ROT_Y_NEG;
        else
            prop_ok = 1'b0;

        // Candidate must hold for the dwell time before adoption
        held = s.t - m_cand_since;
        if (!prop_ok || prop == m_cur_rot) begin
            m_cand_valid = 1'b0;
        end else if (!m_cand_valid || prop != m_cand_rot) begin
            m_cand_valid = 1'b1;
            m_cand_rot = prop;
            m_cand_since = s.t;
        end else if (held >= m_dwell) begin
            m_cur_rot = prop;
            m_cand_valid = 1'b0;
            r.changed = 1'b1;
        end
        r.rotation = m_cur_rot;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [1:0] want_v, logic [1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            n_errors++;
        end
    endfunction

    // Predict on each sample transfer, check each result transfer
    always @(posedge i_clk) begin : monitor
        t_sample s;
        t_result want;
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            s.x = smp_if.accel_x;
            s.y = smp_if.accel_y;
            s.z = smp_if.accel_z;
            s.t = smp_if.time_ms;
            expected_q.push_back(predict_orientation(s));
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: wake %0d rotation %0d changed %0d",
                       res_if.wake, res_if.rotation, res_if.rot_adopted);
                n_errors++;
            end else begin
                want = expected_q.pop_front();
                compare_field("wake", 2'(want.wake), 2'(res_if.wake));
                compare_field("rotation", want.rotation, res_if.rotation);
                compare_field("rot_adopted", 2'(want.changed), 2'(res_if.rot_adopted));
            end
        end
    end

    // Drop ready at random, or for a counted stretch on request
    initial begin : result_receiver
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // End the run when nothing has been transferred for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_QUIET) begin
            @(posedge i_clk);
            if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_accel_wake_and_orientation: errors");
        $finish;
    end

    // Offer one sample after a random gap and hold it until the transfer
    task automatic send_sample(t_sample s);
        while ($urandom_range(0, 99) < tx_idle_pct)
            @(negedge i_clk);
        smp_if.valid = 1'b1;
        smp_if.accel_x = s.x;
        smp_if.accel_y = s.y;
        smp_if.accel_z = s.z;
        smp_if.time_ms = s.t;
        @(posedge i_clk);
        while (!smp_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        smp_if.valid = 1'b0;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, {ADDR_LSB{1'b0}}};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        apply_config(idx, value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Hold off until every expected result has been transferred
    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_SETTLE) @(negedge i_clk);
    endtask

    task automatic load_setting(t_setting which);
        logic [THR_SQ_W-1:0] thr;
        case (which)
            SET_DEFAULT: begin
                write_reg(REG_MOTION_THR_SQ, PDATA_W'(RST_MOTION_THR_SQ));
                write_reg(REG_AXIS_THR, PDATA_W'(RST_AXIS_THR));
                write_reg(REG_DOM_MARGIN, PDATA_W'(RST_DOM_MARGIN));
                write_reg(REG_DWELL_MS, PDATA_W'(RST_DWELL_MS));
                write_reg(REG_TIMEOUT_MS, PDATA_W'(RST_TIMEOUT_MS));
            end
            SET_ZERO: begin
                write_reg(REG_MOTION_THR_SQ, '0);
                write_reg(REG_AXIS_THR, '0);
                write_reg(REG_DOM_MARGIN, '0);
                write_reg(REG_DWELL_MS, '0);
                write_reg(REG_TIMEOUT_MS, '0);
            end
            SET_MAX: begin
                write_reg(REG_MOTION_THR_SQ, PDATA_W'({THR_SQ_W{1'b1}}));
                write_reg(REG_AXIS_THR, PDATA_W'({AXIS_W{1'b1}}));
                write_reg(REG_DOM_MARGIN, PDATA_W'({AXIS_W{1'b1}}));
                write_reg(REG_DWELL_MS, PDATA_W'({MS_W{1'b1}}));
                write_reg(REG_TIMEOUT_MS, PDATA_W'({MS_W{1'b1}}));
            end
            default: begin
                if ($urandom_range(0, 3) == 0)
                    thr = THR_SQ_W'({$urandom(), $urandom()});
                else
                    thr = THR_SQ_W'($urandom_range(0, 4000000));
                write_reg(REG_MOTION_THR_SQ, PDATA_W'(thr));
                write_reg(REG_AXIS_THR, PDATA_W'($urandom_range(500, 9000)));
                write_reg(REG_DOM_MARGIN, PDATA_W'($urandom_range(0, 3000)));
                write_reg(REG_DWELL_MS, PDATA_W'($urandom_range(0, 800)));
                write_reg(REG_TIMEOUT_MS, PDATA_W'($urandom_range(300, 3000)));
            end
        endcase
    endtask

    function automatic t_sample mk_sample(int x, int y, int z, logic [TB-1:0] t);
        t_sample s;
        s.x = SB'(x);
        s.y = SB'(y);
        s.z = SB'(z);
        s.t = t;
        return s;
    endfunction

    function automatic int clamp_sample(int v);
        if (v > S_MAX)
            return S_MAX;
        if (v < S_MIN)
            return S_MIN;
        return v;
    endfunction

    function automatic int jitter(int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    // Hold a pose for a run of samples with noise, jolts and odd timestamps
    function automatic t_sample next_motion_sample();
        t_sample s;
        t_pose kind;
        int mag;
        int amp;
        int roll;
        if (pose_left == 0) begin
            pose_left = int'($urandom_range(1, 12));
            kind = t_pose'($urandom_range(0, int'(POSE_WILD)));
            mag = int'($urandom_range(1500, -S_MIN));
            pose_x = jitter(1500);
            pose_y = jitter(1500);
            pose_z = jitter(1500);
            case (kind)
                POSE_X_POS: pose_x = mag;
                POSE_X_NEG: pose_x = -mag;
                POSE_Y_POS: pose_y = mag;
                POSE_Y_NEG: pose_y = -mag;
                POSE_FLAT:  pose_z = ($urandom_range(0, 1) == 0) ? mag : -mag;
                default: begin
                    pose_x = jitter(S_MAX);
                    pose_y = jitter(S_MAX);
                    pose_z = jitter(S_MAX);
                end
            endcase
        end
        pose_left--;

        amp = ($urandom_range(0, 9) == 0) ? 6000 : 250;
        s.x = SB'(clamp_sample(pose_x + jitter(amp)));
        s.y = SB'(clamp_sample(pose_y + jitter(amp)));
        s.z = SB'(clamp_sample(pose_z + jitter(amp)));
        if ($urandom_range(0, 99) < 5) begin
            s.x = SB'($urandom());
            s.y = SB'($urandom());
            s.z = SB'($urandom());
        end

        roll = int'($urandom_range(0, 99));
        if (roll < 80)
            clock_ms = clock_ms + $urandom_range(0, 300);
        else if (roll < 92)
            clock_ms = clock_ms + $urandom_range(300, 1500);
        else if (roll < 98)
            clock_ms = clock_ms + $urandom_range(1500, 200000);
        else
            clock_ms = $urandom();
        s.t = clock_ms;
        return s;
    endfunction

    // Orientation changes, motion, timeouts and wrap under the reset settings
    task automatic test_directed_defaults();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        // first sample only loads the reference
        send_sample(mk_sample(0, 0, 4096, 0));
        send_sample(mk_sample(4096, 0, 0, 10));
        send_sample(mk_sample(4096, 0, 0, 20));
        send_sample(mk_sample(4096, 0, 0, 600));
        send_sample(mk_sample(-4096, 0, 0, 610));
        send_sample(mk_sample(0, 4096, 0, 620));
        send_sample(mk_sample(0, 4096, 0, 1200));
        send_sample(mk_sample(0, -4096, 0, 1210));
        // gap past the timeout restarts the candidate
        send_sample(mk_sample(0, -4096, 0, 3000));
        send_sample(mk_sample(0, -4096, 0, 3600));
        send_sample(mk_sample(S_MIN, 0, 0, 3610));
        send_sample(mk_sample(S_MAX, S_MIN, S_MAX, 3620));
        send_sample(mk_sample(S_MIN, S_MIN, S_MIN, 3630));
        send_sample(mk_sample(S_MAX, S_MAX, S_MAX, 3640));
        // dwell measured across the timestamp wrap
        send_sample(mk_sample(S_MIN, 0, 0, 32'hFFFF_FF00));
        send_sample(mk_sample(S_MIN, 0, 0, 32'h0000_0100));
        send_sample(mk_sample(0, 0, 0, 32'h0000_0100));
        // timeout and dominance exactly on their limits
        send_sample(mk_sample(2867, 2130, 0, 32'h0000_0100 + 1000));
        send_sample(mk_sample(2866, 0, 0, 32'h0000_0100 + 1999));
        wait_drained();
        // preset clears continuity, so no timeout on the next sample
        write_reg(REG_ROT_PRESET, PDATA_W'(ROT_Y_NEG));
        send_sample(mk_sample(0, -4096, 0, 32'h0000_0100 + 9000));
        wait_drained();
        write_reg(REG_UNUSED, '1);
        send_sample(mk_sample(0, 4096, 0, 32'h0000_0100 + 9100));
    endtask

    // All-zero and all-ones settings on their boundary samples
    task automatic test_register_extremes();
        wait_drained();
        load_setting(SET_ZERO);
        send_sample(mk_sample(100, -100, 0, 50));
        send_sample(mk_sample(100, -100, 0, 50));
        send_sample(mk_sample(0, 0, 0, 60));
        wait_drained();
        load_setting(SET_MAX);
        write_reg(REG_ROT_PRESET, PDATA_W'(ROT_Y_POS));
        send_sample(mk_sample(S_MIN, 0, 0, 70));
        send_sample(mk_sample(S_MAX, 0, 0, 80));
        send_sample(mk_sample(S_MAX, 1, 0, 90));
        send_sample(mk_sample(0, S_MIN, 0, 100));
    endtask

    // Each setting under each idling pattern
    task automatic test_random_phases();
        t_setting plan[N_SETTINGS] = '{SET_DEFAULT, SET_ZERO, SET_MAX, SET_RANDOM, SET_RANDOM};
        foreach (plan[k]) begin
            for (int p = 0; p < N_IDLE; p++) begin
                wait_drained();
                load_setting(plan[k]);
                write_reg(REG_ROT_PRESET, PDATA_W'($urandom_range(0, 3)));
                tx_idle_pct = idle_tx[p];
                rx_stall_pct = idle_rx[p];
                repeat (PHASE_ITEMS) send_sample(next_motion_sample());
            end
        end
    endtask

    // Long receiver hold-off while samples keep coming
    task automatic test_receiver_hold();
        wait_drained();
        load_setting(SET_DEFAULT);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = RX_HOLD_LEN;
        repeat (40) send_sample(next_motion_sample());
    endtask

    // Sender stops until the pipeline is empty, state carries over
    task automatic test_sender_pause();
        tx_idle_pct = 32;
        rx_stall_pct = 32;
        repeat (30) send_sample(next_motion_sample());
        wait_drained();
        repeat (30) send_sample(next_motion_sample());
    endtask

    initial begin
        i_rst_n = 1'b0;
        smp_if.valid = 1'b0;
        smp_if.accel_x = '0;
        smp_if.accel_y = '0;
        smp_if.accel_z = '0;
        smp_if.time_ms = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reset_model();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_defaults();
        test_register_extremes();
        test_random_phases();
        test_receiver_hold();
        test_sender_pause();

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_accel_wake_and_orientation: clean");
        else
            $display("tb_accel_wake_and_orientation: errors");
        $finish;
    end

endmodule
